### src/active_set_threshold_select_assert.svh
// Assertion macros for the active set threshold selector.
`ifndef ACTIVE_SET_THRESHOLD_SELECT_ASSERT_SVH
`define ACTIVE_SET_THRESHOLD_SELECT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define ASTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);
// Next-cycle implication.
`define ASTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define ASTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### src/asts_pkg.sv
// Shared types and constants of the active set threshold selector.
package asts_pkg;

	localparam int IDX_W       = 14;
	localparam int MAG_W       = 31;
	localparam int CORR_W      = 32;
	localparam int SEL_W       = 7;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 31;
	localparam int DIM_W       = 6;
	localparam int BASES_W     = 5;
	localparam int RC_W        = 12;
	localparam int COL_OFF_W   = 12;
	localparam int BASIS_OFF_W = 17;
	localparam int SUM_W       = 18;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATCH_ROWS  = 3'd0,
		CFG_PATCH_COLS  = 3'd1,
		CFG_BASIS_ROWS  = 3'd2,
		CFG_BASIS_COLS  = 3'd3,
		CFG_BASIS_COUNT = 3'd4,
		CFG_BETA        = 3'd5,
		CFG_MAX_ACTIVE  = 3'd6
	} cfg_idx_t;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SELECT = 6'b000010,
		S_PASS   = 6'b000100,
		S_DECIDE = 6'b001000,
		S_EMIT   = 6'b010000,
		S_NONE   = 6'b100000
	} state_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             last;
	} scan_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [MAG_W-1:0] mag;
	} cand_t;

endpackage

### src/asts_scan.sv
// Scan position counters and coefficient index generation.
module asts_scan #(
	parameter int MAX_ROWS  = 32,
	parameter int MAX_COLS  = 32,
	parameter int MAX_BASES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            clear,
	input  logic                            advance,
	input  logic [asts_pkg::DIM_W-1:0]      patch_rows,
	input  logic [asts_pkg::DIM_W-1:0]      patch_cols,
	input  logic [asts_pkg::DIM_W-1:0]      basis_rows,
	input  logic [asts_pkg::DIM_W-1:0]      basis_cols,
	input  logic [asts_pkg::BASES_W-1:0]    basis_count,
	output asts_pkg::scan_t                 scan
);
	import asts_pkg::*;

	logic [DIM_W-1:0]       r_eff, c_eff, br_eff, bc_eff, last_r, last_c;
	logic [BASES_W-1:0]     b_eff;
	logic [RC_W-1:0]        rc;
	logic [DIM_W-1:0]       row_q, col_q;
	logic [BASES_W-1:0]     basis_q;
	logic [COL_OFF_W-1:0]   col_off_q;
	logic [BASIS_OFF_W-1:0] basis_off_q;
	logic [SUM_W-1:0]       idx_sum;
	logic                   basis_end, col_end, row_end;

	always_comb begin
		if (patch_rows == '0)
			r_eff = DIM_W'(1);
		else if (int'(patch_rows) > MAX_ROWS)
			r_eff = DIM_W'(MAX_ROWS);
		else
			r_eff = patch_rows;

		if (patch_cols == '0)
			c_eff = DIM_W'(1);
		else if (int'(patch_cols) > MAX_COLS)
			c_eff = DIM_W'(MAX_COLS);
		else
			c_eff = patch_cols;

		if (basis_count == '0)
			b_eff = BASES_W'(1);
		else if (int'(basis_count) > MAX_BASES)
			b_eff = BASES_W'(MAX_BASES);
		else
			b_eff = basis_count;

		if (basis_rows == '0)
			br_eff = DIM_W'(1);
		else if (basis_rows > r_eff)
			br_eff = r_eff;
		else
			br_eff = basis_rows;

		if (basis_cols == '0)
			bc_eff = DIM_W'(1);
		else if (basis_cols > c_eff)
			bc_eff = c_eff;
		else
			bc_eff = basis_cols;
	end

	assign last_r    = r_eff - br_eff;
	assign last_c    = c_eff - bc_eff;
	assign rc        = {{(RC_W-DIM_W){1'b0}}, r_eff} * {{(RC_W-DIM_W){1'b0}}, c_eff};
	assign basis_end = (basis_q == b_eff - BASES_W'(1));
	assign col_end   = (col_q == last_c);
	assign row_end   = (row_q == last_r);
	assign idx_sum   = SUM_W'(basis_off_q) + SUM_W'(col_off_q) + SUM_W'(row_q);

	assign scan.idx  = idx_sum[IDX_W-1:0];
	assign scan.last = basis_end && col_end && row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			basis_q     <= '0;
			col_off_q   <= '0;
			basis_off_q <= '0;
		end else if (clear) begin
			row_q       <= '0;
			col_q       <= '0;
			basis_q     <= '0;
			col_off_q   <= '0;
			basis_off_q <= '0;
		end else if (advance) begin
			if (!basis_end) begin
				basis_q     <= basis_q + BASES_W'(1);
				basis_off_q <= basis_off_q + BASIS_OFF_W'(rc);
			end else begin
				basis_q     <= '0;
				basis_off_q <= '0;
				if (!col_end) begin
					col_q     <= col_q + DIM_W'(1);
					col_off_q <= col_off_q + COL_OFF_W'(r_eff);
				end else begin
					col_q     <= '0;
					col_off_q <= '0;
					row_q     <= row_end ? '0 : row_q + DIM_W'(1);
				end
			end
		end
	end

endmodule

### src/active_set_threshold_select.sv
// Top level of the active set threshold selector: candidate store and search sequencer.
// Loading: one correlation value per cycle, busy stays low until the last position.
// After the last position: a select state, then either the candidates directly, or up to
// SEARCH_PASSES passes over the candidates, each followed by a decide state.
// Results stream one per cycle from the cycle after emission starts; the receiver cannot stall.
// Async active-low reset clears control and sets config to its defaults; the stores are not cleared.
`include "active_set_threshold_select_assert.svh"

module active_set_threshold_select #(
	parameter int MAX_ROWS      = 32,
	parameter int MAX_COLS      = 32,
	parameter int MAX_BASES     = 16,
	parameter int MAX_ACTIVE    = 64,
	parameter int SEARCH_PASSES = 29
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [asts_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [asts_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [asts_pkg::CORR_W-1:0] corr_value,
	output logic                               result_valid,
	output logic [asts_pkg::IDX_W-1:0]         coeff_index,
	output logic                               is_last,
	output logic                               none_selected,
	output logic [asts_pkg::SEL_W-1:0]         selected_count
);
	import asts_pkg::*;

	localparam int DEPTH  = MAX_ROWS * MAX_COLS * MAX_BASES;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int RD_W   = (CNT_W > SEL_W) ? CNT_W : SEL_W;
	localparam int PAW    = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
	localparam int PASS_W = $clog2(SEARCH_PASSES + 1);
	localparam logic [CNT_W-1:0]  DEPTH_C   = CNT_W'(DEPTH);
	localparam logic [PASS_W-1:0] PASS_LAST = PASS_W'(SEARCH_PASSES - 1);

	// configuration
	logic [DIM_W-1:0]   patch_rows_q, patch_cols_q, basis_rows_q, basis_cols_q;
	logic [BASES_W-1:0] basis_count_q;
	logic [MAG_W-1:0]   beta_q;
	logic [SEL_W-1:0]   max_active_q;
	logic [SEL_W-1:0]   n_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			patch_rows_q  <= DIM_W'(32);
			patch_cols_q  <= DIM_W'(32);
			basis_rows_q  <= DIM_W'(1);
			basis_cols_q  <= DIM_W'(1);
			basis_count_q <= BASES_W'(16);
			beta_q        <= '0;
			max_active_q  <= SEL_W'(64);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PATCH_ROWS:  patch_rows_q  <= cfg_data[DIM_W-1:0];
				CFG_PATCH_COLS:  patch_cols_q  <= cfg_data[DIM_W-1:0];
				CFG_BASIS_ROWS:  basis_rows_q  <= cfg_data[DIM_W-1:0];
				CFG_BASIS_COLS:  basis_cols_q  <= cfg_data[DIM_W-1:0];
				CFG_BASIS_COUNT: basis_count_q <= cfg_data[BASES_W-1:0];
				CFG_BETA:        beta_q        <= cfg_data[MAG_W-1:0];
				CFG_MAX_ACTIVE:  max_active_q  <= cfg_data[SEL_W-1:0];
				default: ;
			endcase
		end
	end

	assign n_eff = (int'(max_active_q) > MAX_ACTIVE) ? SEL_W'(MAX_ACTIVE) : max_active_q;

	// scan position
	state_t state_q;
	scan_t  scan;
	logic   accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	asts_scan #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_COLS  (MAX_COLS),
		.MAX_BASES (MAX_BASES)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (cfg_we),
		.advance     (accept),
		.patch_rows  (patch_rows_q),
		.patch_cols  (patch_cols_q),
		.basis_rows  (basis_rows_q),
		.basis_cols  (basis_cols_q),
		.basis_count (basis_count_q),
		.scan        (scan)
	);

	// magnitude and candidate test
	logic [CORR_W-1:0] raw;
	logic [MAG_W-1:0]  mag;
	logic              is_cand;

	assign raw     = corr_value[CORR_W-1] ? (CORR_W'(0) - CORR_W'(corr_value))
	                                      : CORR_W'(corr_value);
	assign mag     = raw[CORR_W-1] ? {MAG_W{1'b1}} : raw[MAG_W-1:0];
	assign is_cand = {raw, 1'b0} > {2'b00, beta_q};

	// sequencer state
	logic [CNT_W-1:0]  cand_count_q, total_q;
	logic [MAG_W-1:0]  max_q;
	logic [RD_W-1:0]   rd_addr_q;
	logic              rd_vld_s1;
	logic [SEL_W-1:0]  cnt_q, pcount_q;
	logic              ovf_q, src_pick_q;
	logic [CORR_W-1:0] cutoff_q;
	logic [MAG_W-1:0]  step_q;
	logic [PASS_W-1:0] pass_q;
	logic              emit_vld_s1, emit_last_s1, emit_none_s1;

	// memories
	cand_t            cand_mem [DEPTH];
	cand_t            cand_rd_q;
	logic [IDX_W-1:0] pick_mem [MAX_ACTIVE];
	logic [IDX_W-1:0] pick_rd_q;
	logic             cand_we, pick_we, hit, issue, pass_stop;

	assign cand_we   = accept && is_cand && (cand_count_q < DEPTH_C);
	assign hit       = rd_vld_s1 && ({1'b0, cand_rd_q.mag} > cutoff_q);
	assign pass_stop = (cnt_q >= (n_eff >> 1));
	assign issue     = (rd_addr_q < RD_W'(total_q));
	assign pick_we   = (state_q == S_PASS) && hit && (cnt_q != n_eff);

	always_ff @(posedge clk) begin
		if (cand_we)
			cand_mem[cand_count_q[AW-1:0]] <= '{idx: scan.idx, mag: mag};
		cand_rd_q <= cand_mem[rd_addr_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (pick_we)
			pick_mem[cnt_q[PAW-1:0]] <= cand_rd_q.idx;
		pick_rd_q <= pick_mem[rd_addr_q[PAW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cand_count_q <= '0;
			total_q      <= '0;
			max_q        <= '0;
			rd_addr_q    <= '0;
			rd_vld_s1    <= 1'b0;
			cnt_q        <= '0;
			pcount_q     <= '0;
			ovf_q        <= 1'b0;
			src_pick_q   <= 1'b0;
			cutoff_q     <= '0;
			step_q       <= '0;
			pass_q       <= '0;
			emit_vld_s1  <= 1'b0;
			emit_last_s1 <= 1'b0;
			emit_none_s1 <= 1'b0;
		end else begin
			emit_vld_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cfg_we) begin
						cand_count_q <= '0;
						max_q        <= '0;
					end else if (accept) begin
						if (cand_we)
							cand_count_q <= cand_count_q + CNT_W'(1);
						if (is_cand && mag > max_q)
							max_q <= mag;
						if (scan.last)
							state_q <= S_SELECT;
					end
				end
				S_SELECT: begin
					total_q      <= cand_count_q;
					cand_count_q <= '0;
					max_q        <= '0;
					rd_addr_q    <= '0;
					rd_vld_s1    <= 1'b0;
					cnt_q        <= '0;
					ovf_q        <= 1'b0;
					if (RD_W'(cand_count_q) <= RD_W'(n_eff)) begin
						pcount_q   <= SEL_W'(cand_count_q);
						src_pick_q <= 1'b0;
						state_q    <= (cand_count_q == '0) ? S_NONE : S_EMIT;
					end else begin
						cutoff_q <= CORR_W'(max_q >> 1);
						step_q   <= max_q >> 2;
						pass_q   <= '0;
						state_q  <= S_PASS;
					end
				end
				S_PASS: begin
					if (hit && cnt_q == n_eff) begin
						ovf_q     <= 1'b1;
						rd_vld_s1 <= 1'b0;
						state_q   <= S_DECIDE;
					end else begin
						if (hit)
							cnt_q <= cnt_q + SEL_W'(1);
						if (issue) begin
							rd_addr_q <= rd_addr_q + RD_W'(1);
							rd_vld_s1 <= 1'b1;
						end else begin
							rd_vld_s1 <= 1'b0;
						end
						if (!rd_vld_s1 && !issue)
							state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if ((!ovf_q && pass_stop) || pass_q == PASS_LAST) begin
						pcount_q   <= cnt_q;
						src_pick_q <= 1'b1;
						rd_addr_q  <= '0;
						state_q    <= (cnt_q == '0) ? S_NONE : S_EMIT;
					end else begin
						state_q   <= S_PASS;
						rd_addr_q <= '0;
						cnt_q     <= '0;
						ovf_q     <= 1'b0;
					end
					if (!(!ovf_q && pass_stop)) begin
						cutoff_q <= ovf_q ? cutoff_q + CORR_W'(step_q)
						                  : cutoff_q - CORR_W'(step_q);
						step_q   <= step_q >> 1;
						pass_q   <= pass_q + PASS_W'(1);
					end
				end
				S_EMIT: begin
					emit_vld_s1  <= 1'b1;
					emit_none_s1 <= 1'b0;
					emit_last_s1 <= (rd_addr_q == RD_W'(pcount_q) - RD_W'(1));
					rd_addr_q    <= rd_addr_q + RD_W'(1);
					if (rd_addr_q == RD_W'(pcount_q) - RD_W'(1))
						state_q <= S_IDLE;
				end
				S_NONE: begin
					emit_vld_s1  <= 1'b1;
					emit_none_s1 <= 1'b1;
					emit_last_s1 <= 1'b1;
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid   = emit_vld_s1;
	assign is_last        = emit_last_s1;
	assign none_selected  = emit_none_s1;
	assign selected_count = pcount_q;
	assign coeff_index    = emit_none_s1 ? '0 : (src_pick_q ? pick_rd_q : cand_rd_q.idx);

	`ASTS_ASSERT_IMP(a_result_in_run, clk, arst_n, result_valid, $past(busy), "result strobe outside a run")
	`ASTS_ASSERT_IMP(a_none_form, clk, arst_n, result_valid && none_selected, is_last && selected_count == '0, "empty result malformed")
	`ASTS_ASSERT_NXT(a_last_ends, clk, arst_n, result_valid && is_last, !result_valid, "result after the last one")
	`ASTS_ASSERT_IMP(a_read_in_pass, clk, arst_n, rd_vld_s1, state_q == S_PASS, "candidate read outside a pass")
	`ASTS_ASSERT_IMP(a_emit_nonempty, clk, arst_n, state_q == S_EMIT, pcount_q != '0, "emit with empty pick set")

endmodule
